### hdl/median_filter_3x3_stream_unit_macros.svh
// Assertion macros used by the median filter top level.
// Each macro samples on clk_i and stays quiet while rst_ni is low.
`ifndef MEDIAN_FILTER_3X3_STREAM_UNIT_MACROS_SVH
`define MEDIAN_FILTER_3X3_STREAM_UNIT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define MF3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The expression must never be true outside reset.
`define MF3_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

### hdl/mf3_pkg.sv
// Shared constants and types of the 3x3 median filter.
// Used by the line store, the median unit and the top level.
`default_nettype none

package mf3_pkg;

  localparam int MF3_MAX_WIDTH  = 1024;
  localparam int MF3_PIXEL_BITS = 16;
  localparam int MF3_MAX_HEIGHT = 4096;
  localparam int ROW_W          = 12;
  localparam int OUT_COL_W      = 10;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;
  localparam int WIN_N          = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_INTERIOR = 2'd2
  } cfg_reg_e;

  // Which output pixel a pending result describes, relative to the newest pixel.
  typedef enum logic [1:0] {
    KIND_CENTER = 2'd0,
    KIND_RIGHT  = 2'd1,
    KIND_BELOW  = 2'd2,
    KIND_CORNER = 2'd3
  } kind_e;

endpackage

`default_nettype wire

### hdl/mf3_line_store.sv
// Two row stores holding the two rows above the current pixel.
// Registered read on request accept, write when the item enters the window.
`default_nettype none

module mf3_line_store import mf3_pkg::*; #(
  parameter int MAX_WIDTH  = MF3_MAX_WIDTH,
  parameter int PIXEL_BITS = MF3_PIXEL_BITS,
  localparam int AW        = $clog2(MAX_WIDTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rd_en_i,
  input  wire logic [AW-1:0]         rd_addr_i,
  output logic      [PIXEL_BITS-1:0] older_o,
  output logic      [PIXEL_BITS-1:0] newer_o,
  input  wire logic                  wr_en_i,
  input  wire logic [AW-1:0]         wr_addr_i,
  input  wire logic [PIXEL_BITS-1:0] wr_older_i,
  input  wire logic [PIXEL_BITS-1:0] wr_newer_i
);

  logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] newer_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] older_q, newer_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      older_mem[wr_addr_i] <= wr_older_i;
    end
    if (rd_en_i) begin
      older_q <= older_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      newer_mem[wr_addr_i] <= wr_newer_i;
    end
    if (rd_en_i) begin
      newer_q <= newer_mem[rd_addr_i];
    end
  end

  assign older_o = older_q;
  assign newer_o = newer_q;

endmodule

`default_nettype wire

### hdl/mf3_median.sv
// Rank-select median over the valid part of a 3x3 window.
// Gives twice the median, or the sum of the two middle values for even counts.
`default_nettype none

module mf3_median import mf3_pkg::*; #(
  parameter int PIXEL_BITS = MF3_PIXEL_BITS
) (
  input  wire logic [PIXEL_BITS-1:0] win_i [WIN_N],
  input  wire logic [WIN_N-1:0]      mask_i,
  output logic      [PIXEL_BITS:0]   sum_o
);

  logic [3:0]            rank [WIN_N];
  logic [3:0]            cnt;
  logic [3:0]            lo_idx;
  logic [3:0]            hi_idx;
  logic [PIXEL_BITS-1:0] lo_val;
  logic [PIXEL_BITS-1:0] hi_val;

  // Equal values are ordered by position, so the ranks of valid entries are unique.
  always_comb begin
    cnt = '0;
    for (int i = 0; i < WIN_N; i++) begin
      cnt = cnt + {3'b000, mask_i[i]};
    end
    for (int i = 0; i < WIN_N; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WIN_N; j++) begin
        if (j != i && mask_i[j] &&
            (win_i[j] < win_i[i] || (win_i[j] == win_i[i] && j < i))) begin
          rank[i] = rank[i] + 4'd1;
        end
      end
    end
  end

  always_comb begin
    lo_idx = (cnt - 4'd1) >> 1;
    hi_idx = cnt >> 1;
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < WIN_N; i++) begin
      if (mask_i[i] && rank[i] == lo_idx) begin
        lo_val = lo_val | win_i[i];
      end
      if (mask_i[i] && rank[i] == hi_idx) begin
        hi_val = hi_val | win_i[i];
      end
    end
    sum_o = {1'b0, lo_val} + {1'b0, hi_val};
  end

endmodule

`default_nettype wire

### hdl/median_filter_3x3_stream_unit.sv
// Top level of the streaming 3x3 median filter: counters, window, result issue.
// Depends on mf3_pkg, mf3_line_store, mf3_median and the assertion macros.
//
//   channel   direction  payload (low bit first)
//   s_axis    in         tdata: pixel_value
//   m_axis    out        tdata: median_times_two, out_row, out_column; tlast: last_of_image
//   cfg       in         cfg_index_i: register, cfg_data_i: value
//
// An accepted pixel waits in stage 1 for its row store read, enters the window once stage 2
// is free, and its first result is registered in the output register once that is free.
// One median unit issues one result per cycle while m_axis is ready, so a pixel holds the window
// until all its results are issued: the last pixel of a row has two, a last-row pixel two, four at its end.
// Each result beyond the first stalls s_axis; interior mode adds no such stall.
// Reset clears counters, valid flags and the configuration registers; store contents stay undefined.
// A stalled m_axis holds the output register, then the window, then s_axis.
`default_nettype none

`include "median_filter_3x3_stream_unit_macros.svh"

module median_filter_3x3_stream_unit import mf3_pkg::*; #(
  parameter int MAX_WIDTH  = MF3_MAX_WIDTH,
  parameter int PIXEL_BITS = MF3_PIXEL_BITS,
  localparam int CW        = $clog2(MAX_WIDTH),
  localparam int IN_W      = ((PIXEL_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((PIXEL_BITS + 1 + ROW_W + OUT_COL_W + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_W-1:0]       s_axis_tdata,  // pixel_value
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [OUT_W-1:0]      m_axis_tdata,  // median_times_two, out_row, out_column
  output logic                       m_axis_tlast,  // last_of_image
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  // Configuration.
  logic [CW-1:0]    wm1_q, wm1_d;
  logic [ROW_W-1:0] hm1_q, hm1_d;
  logic             interior_q, interior_d;
  logic             cfg_we;
  logic [13:0]      wv;
  logic [12:0]      hv;

  // Position counters.
  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             in_accept;

  // Stage 1: pixel waiting for its row store read.
  logic                  s1_valid_q, s1_valid_d;
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic [CW-1:0]         s1_col_q;
  logic [ROW_W-1:0]      s1_row_q;
  logic                  s1_lastcol_q, s1_lastrow_q;
  logic                  s1_adv;
  logic [PIXEL_BITS-1:0] older_rd, newer_rd;
  logic [3:0]            s1_pend;
  logic                  s1_c_ge1, s1_r_ge1;

  // Stage 2: window and pending results.
  logic [PIXEL_BITS-1:0] win_q [WIN_N];
  logic [3:0]            pend_q, pend_d;
  logic [CW-1:0]         s2_col_q;
  logic [ROW_W-1:0]      s2_row_q;
  logic                  s2_c_ge2_q, s2_r_ge2_q, s2_last_q, s2_int_q;
  logic [3:0]            pick, rest;
  logic                  issue, s2_free, out_free;
  kind_e                 kind;
  logic [2:0]            row_ok, col_ok;
  logic [WIN_N-1:0]      mask;
  logic [ROW_W-1:0]      res_row;
  logic [CW-1:0]         res_col;
  logic                  res_last;
  logic [PIXEL_BITS:0]   med_sum;
  logic [CW+OUT_COL_W-1:0] col_ext;

  // Output register.
  logic                  m_valid_q, m_valid_d;
  logic [PIXEL_BITS:0]   m_med_q;
  logic [ROW_W-1:0]      m_row_q;
  logic [OUT_COL_W-1:0]  m_col_q;
  logic                  m_last_q;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign wv          = {3'b000, cfg_data_i[10:0]};
  assign hv          = cfg_data_i[12:0];

  always_comb begin
    wm1_d      = wm1_q;
    hm1_d      = hm1_q;
    interior_d = interior_q;
    if (cfg_we) begin
      case (cfg_index_i)
        CFG_WIDTH: begin
          if (wv < 14'd2) begin
            wm1_d = CW'(1);
          end else if (wv > 14'(MAX_WIDTH)) begin
            wm1_d = CW'(MAX_WIDTH - 1);
          end else begin
            wm1_d = CW'(wv - 14'd1);
          end
        end
        CFG_HEIGHT: begin
          if (hv < 13'd2) begin
            hm1_d = ROW_W'(1);
          end else if (hv > 13'(MF3_MAX_HEIGHT)) begin
            hm1_d = ROW_W'(MF3_MAX_HEIGHT - 1);
          end else begin
            hm1_d = ROW_W'(hv - 13'd1);
          end
        end
        CFG_INTERIOR: interior_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q      <= CW'(RST_W - 1);
      hm1_q      <= ROW_W'(1023);
      interior_q <= 1'b0;
    end else begin
      wm1_q      <= wm1_d;
      hm1_q      <= hm1_d;
      interior_q <= interior_d;
    end
  end

  // ---------------- counters and stage 1 ----------------
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Any register write restarts the image at the top left pixel.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we && cfg_index_i <= CFG_INTERIOR) begin
      col_d = '0;
      row_d = '0;
    end else if (in_accept) begin
      if (col_q == wm1_q) begin
        col_d = '0;
        row_d = (row_q == hm1_q) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  assign s1_valid_d = in_accept || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q     <= s_axis_tdata[PIXEL_BITS-1:0];
      s1_col_q     <= col_q;
      s1_row_q     <= row_q;
      s1_lastcol_q <= (col_q == wm1_q);
      s1_lastrow_q <= (row_q == hm1_q);
    end
  end

  mf3_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (col_q),
    .older_o   (older_rd),
    .newer_o   (newer_rd),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_older_i(newer_rd),
    .wr_newer_i(s1_pix_q)
  );

  assign s1_c_ge1 = (s1_col_q != '0);
  assign s1_r_ge1 = (s1_row_q != '0);

  always_comb begin
    if (interior_q) begin
      s1_pend = {3'b000, (|s1_row_q[ROW_W-1:1]) && (|s1_col_q[CW-1:1])};
    end else begin
      s1_pend[0] = s1_r_ge1 && s1_c_ge1;
      s1_pend[1] = s1_r_ge1 && s1_c_ge1 && s1_lastcol_q;
      s1_pend[2] = s1_lastrow_q && s1_c_ge1;
      s1_pend[3] = s1_lastrow_q && s1_c_ge1 && s1_lastcol_q;
    end
  end

  // ---------------- stage 2 ----------------
  assign out_free = !m_valid_q || m_axis_tready;
  assign pick     = pend_q & (~pend_q + 4'd1);
  assign rest     = pend_q & ~pick;
  assign issue    = (pend_q != '0) && out_free;
  assign s2_free  = (pend_q == '0) || (issue && rest == '0);
  assign s1_adv   = s1_valid_q && s2_free;

  always_comb begin
    pend_d = pend_q;
    if (s1_adv) begin
      pend_d = s1_pend;
    end else if (issue) begin
      pend_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i*3]   <= win_q[i*3+1];
        win_q[i*3+1] <= win_q[i*3+2];
      end
      win_q[2]   <= older_rd;
      win_q[5]   <= newer_rd;
      win_q[8]   <= s1_pix_q;
      s2_col_q   <= s1_col_q;
      s2_row_q   <= s1_row_q;
      s2_c_ge2_q <= |s1_col_q[CW-1:1];
      s2_r_ge2_q <= |s1_row_q[ROW_W-1:1];
      s2_last_q  <= s1_lastrow_q && s1_lastcol_q;
      s2_int_q   <= interior_q;
    end
  end

  always_comb begin
    if (pick[0]) begin
      kind = KIND_CENTER;
    end else if (pick[1]) begin
      kind = KIND_RIGHT;
    end else if (pick[2]) begin
      kind = KIND_BELOW;
    end else begin
      kind = KIND_CORNER;
    end
  end

  // Window row 0 is two rows up, column 0 two columns left of the newest pixel.
  always_comb begin
    row_ok   = 3'b111;
    col_ok   = 3'b111;
    res_row  = s2_row_q;
    res_col  = s2_col_q;
    res_last = 1'b0;
    case (kind)
      KIND_CENTER: begin
        if (s2_int_q) begin
          res_row  = s2_row_q - ROW_W'(2);
          res_col  = s2_col_q - CW'(2);
          res_last = s2_last_q;
        end else begin
          row_ok[0] = s2_r_ge2_q;
          col_ok[0] = s2_c_ge2_q;
          res_row   = s2_row_q - ROW_W'(1);
          res_col   = s2_col_q - CW'(1);
        end
      end
      KIND_RIGHT: begin
        row_ok[0] = s2_r_ge2_q;
        col_ok[0] = 1'b0;
        res_row   = s2_row_q - ROW_W'(1);
      end
      KIND_BELOW: begin
        row_ok[0] = 1'b0;
        col_ok[0] = s2_c_ge2_q;
        res_col   = s2_col_q - CW'(1);
      end
      KIND_CORNER: begin
        row_ok[0] = 1'b0;
        col_ok[0] = 1'b0;
        res_last  = 1'b1;
      end
      default: ;
    endcase
    for (int i = 0; i < WIN_N; i++) begin
      mask[i] = row_ok[i/3] && col_ok[i%3];
    end
  end

  mf3_median #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_median (
    .win_i (win_q),
    .mask_i(mask),
    .sum_o (med_sum)
  );

  assign col_ext = {{OUT_COL_W{1'b0}}, res_col};

  // ---------------- output register ----------------
  always_comb begin
    m_valid_d = m_valid_q;
    if (issue) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      m_med_q  <= med_sum;
      m_row_q  <= res_row;
      m_col_q  <= col_ext[OUT_COL_W-1:0];
      m_last_q <= res_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = OUT_W'({m_col_q, m_row_q, m_med_q});

  // ---------------- assertions ----------------
  `MF3_ASSERT_NEVER(a_col_range, col_q > wm1_q, "column counter beyond image width")
  `MF3_ASSERT_NEVER(a_row_range, row_q > hm1_q, "row counter beyond image height")
  `MF3_ASSERT(a_store_hazard, (s1_adv && in_accept) |-> (col_q != s1_col_q), "store collision")
  `MF3_ASSERT_NEVER(a_interior_single, s2_int_q && pend_q[3:1] != '0, "several interior results")

endmodule

`default_nettype wire
